/* rtl/pts_pkg.sv */
// Shared types and codes for the process table scheduler.
// No dependencies; imported by the top level, pts_engine and pts_table.
package pts_pkg;

  // Fixed field widths of the request and result items
  localparam int IDX_FIELD_W   = 4;
  localparam int TIME_FIELD_W  = 16;
  localparam int PRIO_W        = 8;
  localparam int QUANTUM_W     = 8;
  localparam int ENTRY_COUNT_W = 5;
  localparam int CFG_INDEX_W   = 2;
  localparam int CFG_DATA_W    = 8;

  // Request kinds (in_tuser)
  localparam logic REQ_WRITE  = 1'b0;
  localparam logic REQ_SELECT = 1'b1;

  // Configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] CFG_MODE    = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_QUANTUM = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_STEP    = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_COUNT   = 2'd3;

  // Scheduling modes
  typedef enum logic [1:0] {
    MODE_FIRST = 2'd0,
    MODE_RR    = 2'd1,
    MODE_HOLD  = 2'd2,
    MODE_AGE   = 2'd3
  } mode_t;

  // Table port controls driven by the engine
  typedef struct packed {
    logic rd_en;
    logic wr_en;
  } tbl_ctl_t;

endpackage

/* rtl/process_table_scheduler.sv */
// Top level of the process table scheduler: configuration registers,
// request/result channels and output register. Uses pts_pkg, pts_engine,
// pts_table.
//
//  channel | direction | handshake            | payload
//  in_     | request   | in_tvalid/in_tready  | tuser kind, tdata entry fields + tick
//  out_    | result    | out_tvalid/out_tready| tuser found, tdata index + priority
//  cfg_    | write     | cfg_valid/cfg_ready  | cfg_index, cfg_data
//
// A write request, or a select with scan length zero, goes straight to the
// result state. A select while a hold is running makes one table read. A
// select with scan first brings the round-robin start below n (n = scan
// length) by subtraction, then reads one entry per cycle through the single
// read port of the table memory until a ready entry is found or all n are read.
// Reset clears the waiting flags at once; no clearing pass is needed.
// A stalled result sits in the output register while the next request is
// taken; that request finishes once the register frees up.
module process_table_scheduler #(
  parameter int MAX_ENTRIES = 16,
  parameter int TIME_BITS   = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // Request channel
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // [3:0] entry_index, [19:4] arrival_time, [35:20] run_time,
  // [36] is_waiting, [44:37] prio_value, [60:45] sel_tick, [63:61] zero
  input  logic [63:0]                       in_tdata,
  // [0] req_type
  input  logic                              in_tuser,
  // Result channel
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // [3:0] selected_index, [11:4] selected_priority, [15:12] zero
  output logic [15:0]                       out_tdata,
  // [0] found
  output logic                              out_tuser,
  // Configuration write channel
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [pts_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [pts_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import pts_pkg::*;

  localparam int IDX_W = $clog2(MAX_ENTRIES);

  mode_t                    mode_r;
  logic [QUANTUM_W-1:0]     quantum_r;
  logic [PRIO_W-1:0]        step_r;
  logic [ENTRY_COUNT_W-1:0] count_r;

  logic                     eng_idle;
  logic                     in_accept;
  logic                     out_free;
  logic                     res_valid;
  logic                     res_found;
  logic [IDX_FIELD_W-1:0]   res_index;
  logic [PRIO_W-1:0]        res_prio;

  tbl_ctl_t                 tbl_ctl;
  logic [IDX_W-1:0]         tbl_rd_addr;
  logic [IDX_W-1:0]         tbl_wr_addr;
  logic [TIME_BITS-1:0]     tbl_wr_arrival;
  logic [TIME_BITS-1:0]     tbl_wr_runtime;
  logic [PRIO_W-1:0]        tbl_wr_prio;
  logic                     tbl_wr_wait;
  logic [TIME_BITS-1:0]     tbl_rd_arrival;
  logic [TIME_BITS-1:0]     tbl_rd_runtime;
  logic [PRIO_W-1:0]        tbl_rd_prio;
  logic                     tbl_rd_wait;

  logic                     out_valid_r;
  logic                     out_found_r;
  logic [IDX_FIELD_W-1:0]   out_index_r;
  logic [PRIO_W-1:0]        out_prio_r;

  // Configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= MODE_FIRST;
      quantum_r <= QUANTUM_W'(1);
      step_r    <= '0;
      count_r   <= ENTRY_COUNT_W'(16);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_MODE:    mode_r    <= mode_t'(cfg_data[1:0]);
        CFG_QUANTUM: quantum_r <= cfg_data;
        CFG_STEP:    step_r    <= cfg_data;
        CFG_COUNT:   count_r   <= cfg_data[ENTRY_COUNT_W-1:0];
        default:     mode_r    <= mode_r;
      endcase
    end
  end

  assign in_tready = eng_idle;
  assign in_accept = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;

  pts_engine #(
    .MAX_ENTRIES (MAX_ENTRIES),
    .TIME_BITS   (TIME_BITS)
  ) u_engine (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (in_accept),
    .idle           (eng_idle),
    .req_type       (in_tuser),
    .entry_index    (in_tdata[3:0]),
    .arrival_time   (in_tdata[19:4]),
    .run_time       (in_tdata[35:20]),
    .is_waiting     (in_tdata[36]),
    .prio_value     (in_tdata[44:37]),
    .sel_tick       (in_tdata[60:45]),
    .sched_mode     (mode_r),
    .quantum        (quantum_r),
    .priority_step  (step_r),
    .entry_count    (count_r),
    .out_free       (out_free),
    .res_valid      (res_valid),
    .res_found      (res_found),
    .res_index      (res_index),
    .res_prio       (res_prio),
    .tbl_ctl        (tbl_ctl),
    .tbl_rd_addr    (tbl_rd_addr),
    .tbl_wr_addr    (tbl_wr_addr),
    .tbl_wr_arrival (tbl_wr_arrival),
    .tbl_wr_runtime (tbl_wr_runtime),
    .tbl_wr_prio    (tbl_wr_prio),
    .tbl_wr_wait    (tbl_wr_wait),
    .tbl_rd_arrival (tbl_rd_arrival),
    .tbl_rd_runtime (tbl_rd_runtime),
    .tbl_rd_prio    (tbl_rd_prio),
    .tbl_rd_wait    (tbl_rd_wait)
  );

  pts_table #(
    .MAX_ENTRIES (MAX_ENTRIES),
    .TIME_BITS   (TIME_BITS)
  ) u_table (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl        (tbl_ctl),
    .rd_addr    (tbl_rd_addr),
    .wr_addr    (tbl_wr_addr),
    .wr_arrival (tbl_wr_arrival),
    .wr_runtime (tbl_wr_runtime),
    .wr_prio    (tbl_wr_prio),
    .wr_wait    (tbl_wr_wait),
    .rd_arrival (tbl_rd_arrival),
    .rd_runtime (tbl_rd_runtime),
    .rd_prio    (tbl_rd_prio),
    .rd_wait    (tbl_rd_wait)
  );

  // Output register: load a finished result, drop it when taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_valid) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      out_found_r <= res_found;
      out_index_r <= res_index;
      out_prio_r  <= res_prio;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_found_r;
  assign out_tdata  = {4'b0000, out_prio_r, out_index_r};

endmodule

/* rtl/pts_table.sv */
// Process table storage: one synchronous memory for arrival, run time and
// priority, plus reset-cleared waiting flags. Depends on pts_pkg.
module pts_table #(
  parameter int MAX_ENTRIES = 16,
  parameter int TIME_BITS   = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  pts_pkg::tbl_ctl_t              ctl,
  input  logic [$clog2(MAX_ENTRIES)-1:0] rd_addr,
  input  logic [$clog2(MAX_ENTRIES)-1:0] wr_addr,
  input  logic [TIME_BITS-1:0]           wr_arrival,
  input  logic [TIME_BITS-1:0]           wr_runtime,
  input  logic [pts_pkg::PRIO_W-1:0]     wr_prio,
  input  logic                           wr_wait,
  output logic [TIME_BITS-1:0]           rd_arrival,
  output logic [TIME_BITS-1:0]           rd_runtime,
  output logic [pts_pkg::PRIO_W-1:0]     rd_prio,
  output logic                           rd_wait
);
  import pts_pkg::*;

  localparam int WORD_W = 2 * TIME_BITS + PRIO_W;

  logic [WORD_W-1:0]      mem [MAX_ENTRIES];
  logic [MAX_ENTRIES-1:0] wait_r;
  logic [WORD_W-1:0]      rd_word_r;
  logic                   rd_wait_r;

  // Write port and registered read port of the entry memory
  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[wr_addr] <= {wr_arrival, wr_runtime, wr_prio};
    end
    if (ctl.rd_en) begin
      rd_word_r <= mem[rd_addr];
    end
  end

  // Waiting flags clear at reset; read alongside the memory word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wait_r    <= '0;
      rd_wait_r <= 1'b0;
    end else begin
      if (ctl.wr_en) begin
        wait_r[wr_addr] <= wr_wait;
      end
      if (ctl.rd_en) begin
        rd_wait_r <= wait_r[rd_addr];
      end
    end
  end

  assign rd_arrival = rd_word_r[WORD_W-1 -: TIME_BITS];
  assign rd_runtime = rd_word_r[PRIO_W +: TIME_BITS];
  assign rd_prio    = rd_word_r[PRIO_W-1:0];
  assign rd_wait    = rd_wait_r;

endmodule

/* rtl/pts_engine.sv */
// Request sequencer: table writes, hold bookkeeping and the entry-by-entry
// ready scan over the table memory. Depends on pts_pkg and drives pts_table.
module pts_engine #(
  parameter int MAX_ENTRIES = 16,
  parameter int TIME_BITS   = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // request
  input  logic                                start,
  output logic                                idle,
  input  logic                                req_type,
  input  logic [pts_pkg::IDX_FIELD_W-1:0]     entry_index,
  input  logic [pts_pkg::TIME_FIELD_W-1:0]    arrival_time,
  input  logic [pts_pkg::TIME_FIELD_W-1:0]    run_time,
  input  logic                                is_waiting,
  input  logic [pts_pkg::PRIO_W-1:0]          prio_value,
  input  logic [pts_pkg::TIME_FIELD_W-1:0]    sel_tick,
  // configuration
  input  pts_pkg::mode_t                      sched_mode,
  input  logic [pts_pkg::QUANTUM_W-1:0]       quantum,
  input  logic [pts_pkg::PRIO_W-1:0]          priority_step,
  input  logic [pts_pkg::ENTRY_COUNT_W-1:0]   entry_count,
  // result
  input  logic                                out_free,
  output logic                                res_valid,
  output logic                                res_found,
  output logic [pts_pkg::IDX_FIELD_W-1:0]     res_index,
  output logic [pts_pkg::PRIO_W-1:0]          res_prio,
  // table port
  output pts_pkg::tbl_ctl_t                   tbl_ctl,
  output logic [$clog2(MAX_ENTRIES)-1:0]      tbl_rd_addr,
  output logic [$clog2(MAX_ENTRIES)-1:0]      tbl_wr_addr,
  output logic [TIME_BITS-1:0]                tbl_wr_arrival,
  output logic [TIME_BITS-1:0]                tbl_wr_runtime,
  output logic [pts_pkg::PRIO_W-1:0]          tbl_wr_prio,
  output logic                                tbl_wr_wait,
  input  logic [TIME_BITS-1:0]                tbl_rd_arrival,
  input  logic [TIME_BITS-1:0]                tbl_rd_runtime,
  input  logic [pts_pkg::PRIO_W-1:0]          tbl_rd_prio,
  input  logic                                tbl_rd_wait
);
  import pts_pkg::*;

  localparam int IDX_W = $clog2(MAX_ENTRIES);
  localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
  localparam int N_W   = (CNT_W > ENTRY_COUNT_W) ? CNT_W : ENTRY_COUNT_W;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_MOD  = 5'b00010,
    S_SCAN = 5'b00100,
    S_HOLD = 5'b01000,
    S_FIN  = 5'b10000
  } state_t;

  state_t               state_r,     state_nxt;
  logic [TIME_BITS-1:0] now_r,       now_nxt;
  logic [N_W-1:0]       start_r,     start_nxt;
  logic [IDX_W-1:0]     addr_r,      addr_nxt;
  logic [N_W-1:0]       cnt_r,       cnt_nxt;
  logic                 pend_v_r,    pend_v_nxt;
  logic [IDX_W-1:0]     pend_addr_r, pend_addr_nxt;
  logic [IDX_W-1:0]     pick_r,      pick_nxt;
  logic [IDX_W-1:0]     rr_pos_r,    rr_pos_nxt;
  logic                 rr_valid_r,  rr_valid_nxt;
  logic [IDX_W-1:0]     held_r,      held_nxt;
  logic [TIME_BITS-1:0] hold_r,      hold_nxt;
  logic                 found_r,     found_nxt;
  logic [IDX_FIELD_W-1:0] index_r,   index_nxt;
  logic [PRIO_W-1:0]    prio_r,      prio_nxt;

  logic [N_W-1:0]       ec_ext;
  logic [N_W-1:0]       n_used;
  logic                 hold_sel;
  logic [IDX_W-1:0]     hold_pick;
  logic                 issue;
  logic                 hit;
  logic [TIME_BITS-1:0] quantum_ext;
  logic [TIME_BITS-1:0] slice;
  logic [PRIO_W:0]      aged_sum;
  logic [PRIO_W-1:0]    aged_prio;

  function automatic logic [TIME_BITS-1:0] hold_after(input logic [TIME_BITS-1:0] ticks);
    return (ticks == '0) ? '0 : ticks - TIME_BITS'(1);
  endfunction

  // Scan length: entry count clamped to the table depth
  assign ec_ext = N_W'(entry_count);
  assign n_used = (ec_ext > N_W'(MAX_ENTRIES)) ? N_W'(MAX_ENTRIES) : ec_ext;

  assign hold_sel  = ((sched_mode == MODE_RR) || (sched_mode == MODE_HOLD)) &&
                     (hold_r != '0);
  assign hold_pick = (sched_mode == MODE_RR) ? rr_pos_r : held_r;

  // Scan compare on the word returned for the previous address
  assign issue = (cnt_r < n_used);
  assign hit   = pend_v_r && tbl_rd_wait && (tbl_rd_arrival <= now_r);

  assign quantum_ext = TIME_BITS'(quantum);
  assign slice       = (quantum_ext < tbl_rd_runtime) ? quantum_ext : tbl_rd_runtime;
  assign aged_sum    = {1'b0, tbl_rd_prio} + {1'b0, priority_step};
  assign aged_prio   = aged_sum[PRIO_W] ? {PRIO_W{1'b1}} : aged_sum[PRIO_W-1:0];

  // Sequencer next state
  always_comb begin
    state_nxt     = state_r;
    now_nxt       = now_r;
    start_nxt     = start_r;
    addr_nxt      = addr_r;
    cnt_nxt       = cnt_r;
    pend_v_nxt    = pend_v_r;
    pend_addr_nxt = pend_addr_r;
    pick_nxt      = pick_r;
    rr_pos_nxt    = rr_pos_r;
    rr_valid_nxt  = rr_valid_r;
    held_nxt      = held_r;
    hold_nxt      = hold_r;
    found_nxt     = found_r;
    index_nxt     = index_r;
    prio_nxt      = prio_r;
    res_valid     = 1'b0;

    tbl_ctl        = '0;
    tbl_rd_addr    = addr_r;
    tbl_wr_addr    = pend_addr_r;
    tbl_wr_arrival = tbl_rd_arrival;
    tbl_wr_runtime = tbl_rd_runtime;
    tbl_wr_prio    = aged_prio;
    tbl_wr_wait    = tbl_rd_wait;

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          if (req_type == REQ_WRITE) begin
            // Write the entry now; indexes past the table are dropped
            if (32'(entry_index) < MAX_ENTRIES) begin
              tbl_ctl.wr_en = 1'b1;
            end
            tbl_wr_addr    = IDX_W'(entry_index);
            tbl_wr_arrival = TIME_BITS'(arrival_time);
            tbl_wr_runtime = TIME_BITS'(run_time);
            tbl_wr_prio    = prio_value;
            tbl_wr_wait    = is_waiting;
            found_nxt      = 1'b0;
            index_nxt      = '0;
            prio_nxt       = '0;
            state_nxt      = S_FIN;
          end else begin
            now_nxt = TIME_BITS'(sel_tick);
            if (hold_sel) begin
              // Keep serving the held entry; fetch its priority
              hold_nxt      = hold_r - TIME_BITS'(1);
              tbl_ctl.rd_en = 1'b1;
              tbl_rd_addr   = hold_pick;
              pick_nxt      = hold_pick;
              state_nxt     = S_HOLD;
            end else if (n_used == '0) begin
              found_nxt = 1'b0;
              index_nxt = '0;
              prio_nxt  = '0;
              state_nxt = S_FIN;
            end else begin
              start_nxt = (sched_mode == MODE_RR && rr_valid_r) ?
                          N_W'(rr_pos_r) + N_W'(1) : '0;
              state_nxt = S_MOD;
            end
          end
        end
      end

      S_MOD: begin
        // Reduce the scan start below the scan length
        if (start_r >= n_used) begin
          start_nxt = start_r - n_used;
        end else begin
          addr_nxt   = IDX_W'(start_r);
          cnt_nxt    = '0;
          pend_v_nxt = 1'b0;
          state_nxt  = S_SCAN;
        end
      end

      S_SCAN: begin
        // Issue one read per cycle, wrapping at the scan length
        tbl_ctl.rd_en = issue;
        pend_v_nxt    = issue;
        pend_addr_nxt = addr_r;
        if (issue) begin
          cnt_nxt  = cnt_r + N_W'(1);
          addr_nxt = ((N_W'(addr_r) + N_W'(1)) == n_used) ? '0 : addr_r + IDX_W'(1);
        end
        if (hit) begin
          found_nxt = 1'b1;
          index_nxt = IDX_FIELD_W'(pend_addr_r);
          prio_nxt  = tbl_rd_prio;
          unique case (sched_mode)
            MODE_RR: begin
              rr_pos_nxt   = pend_addr_r;
              rr_valid_nxt = 1'b1;
              hold_nxt     = hold_after(slice);
            end
            MODE_HOLD: begin
              held_nxt = pend_addr_r;
              hold_nxt = hold_after(tbl_rd_runtime);
            end
            MODE_AGE: begin
              // Write back the aged priority
              tbl_ctl.wr_en = 1'b1;
              prio_nxt      = aged_prio;
            end
            MODE_FIRST: begin
              prio_nxt = tbl_rd_prio;
            end
            default: begin
              prio_nxt = tbl_rd_prio;
            end
          endcase
          state_nxt = S_FIN;
        end else if (!issue && !pend_v_r) begin
          found_nxt = 1'b0;
          index_nxt = '0;
          prio_nxt  = '0;
          state_nxt = S_FIN;
        end
      end

      S_HOLD: begin
        found_nxt = 1'b1;
        index_nxt = IDX_FIELD_W'(pick_r);
        prio_nxt  = tbl_rd_prio;
        state_nxt = S_FIN;
      end

      S_FIN: begin
        // Hand the result over once the output register has room
        if (out_free) begin
          res_valid = 1'b1;
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      pend_v_r   <= 1'b0;
      cnt_r      <= '0;
      rr_pos_r   <= '0;
      rr_valid_r <= 1'b0;
      held_r     <= '0;
      hold_r     <= '0;
    end else begin
      state_r    <= state_nxt;
      pend_v_r   <= pend_v_nxt;
      cnt_r      <= cnt_nxt;
      rr_pos_r   <= rr_pos_nxt;
      rr_valid_r <= rr_valid_nxt;
      held_r     <= held_nxt;
      hold_r     <= hold_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    now_r       <= now_nxt;
    start_r     <= start_nxt;
    addr_r      <= addr_nxt;
    pend_addr_r <= pend_addr_nxt;
    pick_r      <= pick_nxt;
    found_r     <= found_nxt;
    index_r     <= index_nxt;
    prio_r      <= prio_nxt;
  end

  assign idle      = (state_r == S_IDLE);
  assign res_found = found_r;
  assign res_index = index_r;
  assign res_prio  = prio_r;

endmodule

/* rtl/pts_checker.sv */
// Port-level checks for the process table scheduler, attached by bind.
// Sees only the top-level ports; no package needed.
module pts_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [15:0] out_tdata,
  input logic        out_tuser
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled result dropped or changed");

  // One request in flight: no request is taken right after another
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("request taken while previous one still in work");

  // A result with no selection carries zero index and priority
  a_none_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tdata == 16'h0000)
    else $error("empty result carries nonzero payload");

  // No result right out of reset
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result shown after reset");

endmodule

bind process_table_scheduler pts_checker u_pts_checker (.*);
